/* rtl/lens_distortion_coordinate_map_core_macros.svh */
// ----------------------------------------------------------------------------
// lens distortion coordinate map assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef LENS_DISTORTION_COORDINATE_MAP_CORE_MACROS_SVH
`define LENS_DISTORTION_COORDINATE_MAP_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LDCM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldcm check failed");

// condition never holds
`define LDCM_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ldcm check failed");

`endif

/* rtl/ldcm_pkg.sv */
// ----------------------------------------------------------------------------
// ldcm_pkg
// types, constants and fixed point helpers of the distortion coordinate map
// ----------------------------------------------------------------------------
`default_nettype none

package ldcm_pkg;

   typedef logic signed [23:0] q_type;

   typedef enum logic [2:0] {
      REG_FOCAL_X  = 3'd0,
      REG_FOCAL_Y  = 3'd1,
      REG_CENTER_X = 3'd2,
      REG_CENTER_Y = 3'd3,
      REG_K1       = 3'd4,
      REG_K2       = 3'd5,
      REG_P1       = 3'd6,
      REG_P2       = 3'd7
   } csr_index_type;

   localparam logic signed [49:0] Q_MAX   = 50'sd8388607;
   localparam logic signed [49:0] Q_MIN   = -50'sd8388608;
   localparam logic signed [49:0] ONE_Q20 = 50'sd1048576;

   localparam logic [19:0] FOCAL_RESET  = 20'd262144;
   localparam logic [19:0] CENTER_RESET = 20'd262144;

   function automatic q_type sat24(input logic signed [49:0] v);
      q_type r;
      if (v > Q_MAX) begin
         r = q_type'(Q_MAX);
      end else if (v < Q_MIN) begin
         r = q_type'(Q_MIN);
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   // floor of a q20 product by 2^20
   function automatic logic signed [27:0] fl20(input logic signed [47:0] p);
      return $signed(p[47:20]);
   endfunction

endpackage

`default_nettype wire

/* rtl/ldcm_div.sv */
// ----------------------------------------------------------------------------
// ldcm_div
// pipelined restoring divider: sat(trunc(diff * 2^20 / focal)), four bits a stage
// ----------------------------------------------------------------------------
`default_nettype none

module ldcm_div import ldcm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [20:0]  in_diff,
   input  logic [19:0]         focal,
   output logic                out_valid,
   output q_type               out_quot
);

   localparam int STEPS  = 4;
   localparam int STAGES = 24 / STEPS;

   logic              valid_ff [0:STAGES+1];
   logic [19:0]       rem_ff   [0:STAGES];
   logic [23:0]       num_ff   [0:STAGES];
   logic [23:0]       quo_ff   [0:STAGES];
   logic              neg_ff   [0:STAGES];
   logic              ovf_ff   [0:STAGES];
   logic [19:0]       rem_in   [1:STAGES];
   logic [23:0]       num_in   [1:STAGES];
   logic [23:0]       quo_in   [1:STAGES];
   logic [19:0]       div_eff;
   logic [20:0]       mag_wide;
   logic [19:0]       mag;
   q_type             quot_in;
   q_type             quot_ff;

   assign div_eff  = (focal == 20'd0) ? 20'd1 : focal;
   assign mag_wide = in_diff[20] ? 21'(-in_diff) : 21'(in_diff);
   assign mag      = mag_wide[19:0];

   always_comb begin
      logic [20:0] t;
      logic [19:0] r;
      logic [23:0] n;
      logic [23:0] q;
      t = '0;
      for (int s = 1; s <= STAGES; s++) begin
         r = rem_ff[s-1];
         n = num_ff[s-1];
         q = quo_ff[s-1];
         for (int k = 0; k < STEPS; k++) begin
            t = {r, n[23]};
            n = {n[22:0], 1'b0};
            if (t >= {1'b0, div_eff}) begin
               t = t - {1'b0, div_eff};
               q = {q[22:0], 1'b1};
            end else begin
               q = {q[22:0], 1'b0};
            end
            r = t[19:0];
         end
         rem_in[s] = r;
         num_in[s] = n;
         quo_in[s] = q;
      end
   end

   always_comb begin
      logic [23:0] q;
      q = quo_ff[STAGES];
      if (!neg_ff[STAGES]) begin
         quot_in = (ovf_ff[STAGES] || q[23]) ? q_type'(Q_MAX) : $signed(q);
      end else if (ovf_ff[STAGES] || (q > 24'd8388608)) begin
         quot_in = q_type'(Q_MIN);
      end else begin
         quot_in = $signed(-q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STAGES + 1; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= STAGES + 1; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= {4'd0, mag[19:4]};
      num_ff[0] <= {mag[3:0], 20'd0};
      quo_ff[0] <= '0;
      neg_ff[0] <= in_diff[20];
      ovf_ff[0] <= ({4'd0, mag} >= {div_eff, 4'd0});
      for (int s = 1; s <= STAGES; s++) begin
         rem_ff[s] <= rem_in[s];
         num_ff[s] <= num_in[s];
         quo_ff[s] <= quo_in[s];
         neg_ff[s] <= neg_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
      end
      quot_ff <= quot_in;
   end

   assign out_valid = valid_ff[STAGES+1];
   assign out_quot  = quot_ff;

endmodule

`default_nettype wire

/* rtl/lens_distortion_coordinate_map_core.sv */
// ----------------------------------------------------------------------------
// lens_distortion_coordinate_map_core
// brown-conrady radial and tangential distortion map, output pixel to source
//
//   channel   ports                                   transfer
//   request   start, busy, req_out_col/row            start high, busy low
//   response  rsp_strobe, rsp_src_col/row, in_frame   rsp_strobe high
//   config    csr_write_enable, csr_index, data       write enable high
//
// one item a cycle
// the 24-bit quotient pipeline works four bits a stage
// busy stays low, the pipeline never stalls
// reset clears the valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module lens_distortion_coordinate_map_core import ldcm_pkg::*; #(
   parameter int SRC_WIDTH  = 2048,
   parameter int SRC_HEIGHT = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_out_col,
   input  logic [11:0] req_out_row,
   output logic        rsp_strobe,
   output logic [11:0] rsp_src_col,
   output logic [11:0] rsp_src_row,
   output logic        rsp_in_frame,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   localparam logic signed [20:0] W_LIM = 21'(SRC_WIDTH);
   localparam logic signed [20:0] H_LIM = 21'(SRC_HEIGHT);
   localparam int POST = 8;

   logic [19:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   q_type       k1_ff, k2_ff, p1_ff, p2_ff;

   logic               t0_valid_ff;
   logic signed [20:0] dx_ff, dy_ff;
   logic               div_valid, div_valid_y;
   q_type              xx_q, yy_q;
   logic               valid_ff [1:POST];

   // stage 1
   q_type xx1_ff, yy1_ff, xsq1_ff, ysq1_ff, xy1_ff;
   // stage 2
   q_type xx2_ff, yy2_ff, xsq2_ff, ysq2_ff, xy2_ff, r2_2_ff;
   // stage 3
   q_type xx3_ff, yy3_ff, xy3_ff, r4_3_ff, sx3_ff, sy3_ff;
   logic signed [27:0] k1r2_3_ff;
   // stage 4
   q_type xx4_ff, yy4_ff, xy4_ff, sx4_ff, sy4_ff, rad4_ff;
   // stage 5
   q_type xr5_ff, yr5_ff;
   logic signed [27:0] t1_5_ff, t2_5_ff, t3_5_ff, t4_5_ff;
   // stage 6
   q_type xd6_ff, yd6_ff;
   // stage 7
   logic signed [44:0] px7_ff, py7_ff;
   // stage 8
   logic [11:0] col_ff, row_ff;
   logic        frame_ff;

   logic signed [47:0] s_x, s_y;
   logic signed [20:0] u_in, v_in;
   logic               ok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FOCAL_RESET;
         focal_y_ff  <= FOCAL_RESET;
         center_x_ff <= CENTER_RESET;
         center_y_ff <= CENTER_RESET;
         k1_ff       <= '0;
         k2_ff       <= '0;
         p1_ff       <= '0;
         p2_ff       <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_FOCAL_X:  focal_x_ff  <= csr_write_data[19:0];
            REG_FOCAL_Y:  focal_y_ff  <= csr_write_data[19:0];
            REG_CENTER_X: center_x_ff <= csr_write_data[19:0];
            REG_CENTER_Y: center_y_ff <= csr_write_data[19:0];
            REG_K1:       k1_ff       <= $signed(csr_write_data);
            REG_K2:       k2_ff       <= $signed(csr_write_data);
            REG_P1:       p1_ff       <= $signed(csr_write_data);
            REG_P2:       p2_ff       <= $signed(csr_write_data);
         endcase
      end
   end

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
      end else begin
         t0_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= $signed({1'b0, req_out_col, 8'd0}) - $signed({1'b0, center_x_ff});
      dy_ff <= $signed({1'b0, req_out_row, 8'd0}) - $signed({1'b0, center_y_ff});
   end

   ldcm_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t0_valid_ff),
      .in_diff   (dx_ff),
      .focal     (focal_x_ff),
      .out_valid (div_valid),
      .out_quot  (xx_q)
   );

   ldcm_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t0_valid_ff),
      .in_diff   (dy_ff),
      .focal     (focal_y_ff),
      .out_valid (div_valid_y),
      .out_quot  (yy_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= POST; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[1] <= div_valid && div_valid_y;
         for (int s = 2; s <= POST; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_comb begin
      s_x  = 48'(px7_ff) + $signed({8'd0, center_x_ff, 20'd0});
      s_y  = 48'(py7_ff) + $signed({8'd0, center_y_ff, 20'd0});
      // truncate toward zero
      if (s_x[47]) begin
         s_x = s_x + 48'sd268435455;
      end
      if (s_y[47]) begin
         s_y = s_y + 48'sd268435455;
      end
      u_in  = 21'($signed(s_x[47:28]));
      v_in  = 21'($signed(s_y[47:28]));
      ok_in = (u_in > 21'sd0) && (u_in < W_LIM) && (v_in > 21'sd0) && (v_in < H_LIM);
   end

   always_ff @(posedge clock) begin
      // squares and cross term
      xx1_ff  <= xx_q;
      yy1_ff  <= yy_q;
      xsq1_ff <= sat24(50'(fl20(48'(xx_q * xx_q))));
      ysq1_ff <= sat24(50'(fl20(48'(yy_q * yy_q))));
      xy1_ff  <= sat24(50'(fl20(48'(xx_q * yy_q))));
      // radius squared
      xx2_ff  <= xx1_ff;
      yy2_ff  <= yy1_ff;
      xsq2_ff <= xsq1_ff;
      ysq2_ff <= ysq1_ff;
      xy2_ff  <= xy1_ff;
      r2_2_ff <= sat24(50'(xsq1_ff) + 50'(ysq1_ff));
      // r4, k1 term, tangential radii
      xx3_ff    <= xx2_ff;
      yy3_ff    <= yy2_ff;
      xy3_ff    <= xy2_ff;
      r4_3_ff   <= sat24(50'(fl20(48'(r2_2_ff * r2_2_ff))));
      k1r2_3_ff <= fl20(48'(k1_ff * r2_2_ff));
      sx3_ff    <= sat24(50'(r2_2_ff) + 50'(xsq2_ff) + 50'(xsq2_ff));
      sy3_ff    <= sat24(50'(r2_2_ff) + 50'(ysq2_ff) + 50'(ysq2_ff));
      // radial factor
      xx4_ff  <= xx3_ff;
      yy4_ff  <= yy3_ff;
      xy4_ff  <= xy3_ff;
      sx4_ff  <= sx3_ff;
      sy4_ff  <= sy3_ff;
      rad4_ff <= sat24(ONE_Q20 + 50'(k1r2_3_ff) + 50'(fl20(48'(k2_ff * r4_3_ff))));
      // products
      xr5_ff  <= sat24(50'(fl20(48'(xx4_ff * rad4_ff))));
      yr5_ff  <= sat24(50'(fl20(48'(yy4_ff * rad4_ff))));
      t1_5_ff <= fl20(48'(p1_ff * xy4_ff));
      t2_5_ff <= fl20(48'(p2_ff * sx4_ff));
      t3_5_ff <= fl20(48'(p2_ff * xy4_ff));
      t4_5_ff <= fl20(48'(p1_ff * sy4_ff));
      // distorted position
      xd6_ff <= sat24(50'(xr5_ff) + 50'(t1_5_ff) + 50'(t1_5_ff) + 50'(t2_5_ff));
      yd6_ff <= sat24(50'(yr5_ff) + 50'(t3_5_ff) + 50'(t3_5_ff) + 50'(t4_5_ff));
      // back to pixels
      px7_ff <= 45'(xd6_ff * $signed({1'b0, focal_x_ff}));
      py7_ff <= 45'(yd6_ff * $signed({1'b0, focal_y_ff}));
      // frame check
      col_ff   <= ok_in ? u_in[11:0] : 12'd0;
      row_ff   <= ok_in ? v_in[11:0] : 12'd0;
      frame_ff <= ok_in;
   end

   assign rsp_strobe   = valid_ff[POST];
   assign rsp_src_col  = col_ff;
   assign rsp_src_row  = row_ff;
   assign rsp_in_frame = frame_ff && valid_ff[POST];

endmodule

`default_nettype wire

/* rtl/ldcm_checker.sv */
// ----------------------------------------------------------------------------
// ldcm_checker
// port level checks of the distortion coordinate map, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "lens_distortion_coordinate_map_core_macros.svh"

module ldcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [11:0] req_out_col,
   input logic [11:0] req_out_row,
   input logic        rsp_strobe,
   input logic [11:0] rsp_src_col,
   input logic [11:0] rsp_src_row,
   input logic        rsp_in_frame,
   input logic        csr_write_enable,
   input logic [2:0]  csr_index,
   input logic [23:0] csr_write_data
);

   `LDCM_ASSERT_NEVER(a_never_busy, clock, reset, busy)
   `LDCM_ASSERT_IMPL(a_strobe_has_request, clock, reset, rsp_strobe, $past(start, 17))
   `LDCM_ASSERT_IMPL(a_black_zero, clock, reset, rsp_strobe && !rsp_in_frame, (rsp_src_col == 12'd0) && (rsp_src_row == 12'd0))
   `LDCM_ASSERT_IMPL(a_frame_with_strobe, clock, reset, rsp_in_frame, rsp_strobe && (rsp_src_col != 12'd0) && (rsp_src_row != 12'd0))

endmodule

bind lens_distortion_coordinate_map_core ldcm_checker u_ldcm_checker (.*);

`default_nettype wire

/* verif/tb_lens_distortion_coordinate_map_core.sv */
// ----------------------------------------------------------------------------
// tb_lens_distortion_coordinate_map_core
// self-checking bench for the brown-conrady coordinate map: pixel requests go
// in under varied register settings and sender gaps, each response is
// compared field by field with a bit-exact fixed point prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_lens_distortion_coordinate_map_core;
   import ldcm_pkg::*;

   localparam int SRC_W = 2048;
   localparam int SRC_H = 2048;
   localparam int LATENCY = 17;

   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
      logic        in_frame;
   } src_coord_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_out_col;
   logic [11:0] req_out_row;
   logic        rsp_strobe;
   logic [11:0] rsp_src_col;
   logic [11:0] rsp_src_row;
   logic        rsp_in_frame;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [23:0] csr_write_data;

   // shadow registers of the lens model
   logic [19:0]        lens_fx, lens_fy, lens_cx, lens_cy;
   logic signed [23:0] lens_k1, lens_k2, lens_p1, lens_p2;

   src_coord_type expected_coords[$];
   int            mismatches;
   int            pixels_sent;
   int            coords_checked;
   int            in_frame_seen;
   int            sender_idle_pct;
   int            cfg_sets;

   lens_distortion_coordinate_map_core #(
      .SRC_WIDTH (SRC_W),
      .SRC_HEIGHT(SRC_H)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_out_col     (req_out_col),
      .req_out_row     (req_out_row),
      .rsp_strobe      (rsp_strobe),
      .rsp_src_col     (rsp_src_col),
      .rsp_src_row     (rsp_src_row),
      .rsp_in_frame    (rsp_in_frame),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint sat_q20(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint floor_q20(input longint v);
      return v >>> 20;
   endfunction

   function automatic longint norm_axis(input logic [11:0] pos, input logic [19:0] ctr,
                                        input logic [19:0] foc);
      longint d;
      longint f;
      d = longint'(pos) * 256 - longint'(ctr);
      f = (foc == 20'd0) ? 64'sd1 : longint'(foc);
      return sat_q20((d * 64'sd1048576) / f);
   endfunction

   function automatic longint back_to_pixel(input longint q, input logic [19:0] foc,
                                            input logic [19:0] ctr);
      return (q * longint'(foc) + longint'(ctr) * 64'sd1048576) / (64'sd1 <<< 28);
   endfunction

   function automatic src_coord_type distort_pixel(input logic [11:0] col,
                                                   input logic [11:0] row);
      longint xx, yy, xsq, ysq, xy, r2, r4, rad, sx, sy, xd, yd, u, v;
      src_coord_type r;
      xx  = norm_axis(col, lens_cx, lens_fx);
      yy  = norm_axis(row, lens_cy, lens_fy);
      xsq = sat_q20(floor_q20(xx * xx));
      ysq = sat_q20(floor_q20(yy * yy));
      xy  = sat_q20(floor_q20(xx * yy));
      r2  = sat_q20(xsq + ysq);
      r4  = sat_q20(floor_q20(r2 * r2));
      rad = sat_q20(64'sd1048576 + floor_q20(longint'(lens_k1) * r2)
                    + floor_q20(longint'(lens_k2) * r4));
      sx  = sat_q20(r2 + 2 * xsq);
      sy  = sat_q20(r2 + 2 * ysq);
      xd  = sat_q20(sat_q20(floor_q20(xx * rad)) + 2 * floor_q20(longint'(lens_p1) * xy)
                    + floor_q20(longint'(lens_p2) * sx));
      yd  = sat_q20(sat_q20(floor_q20(yy * rad)) + 2 * floor_q20(longint'(lens_p2) * xy)
                    + floor_q20(longint'(lens_p1) * sy));
      u = back_to_pixel(xd, lens_fx, lens_cx);
      v = back_to_pixel(yd, lens_fy, lens_cy);
      r = '0;
      if (u > 0 && u < SRC_W && v > 0 && v < SRC_H) begin
         r.col      = u[11:0];
         r.row      = v[11:0];
         r.in_frame = 1'b1;
      end
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      src_coord_type want;
      if (!reset && rsp_strobe) begin
         if (expected_coords.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected response col=%0d row=%0d in_frame=%0b", $time,
                        rsp_src_col, rsp_src_row, rsp_in_frame);
         end else begin
            want = expected_coords.pop_front();
            coords_checked++;
            if (rsp_in_frame) in_frame_seen++;
            if (rsp_src_col !== want.col || rsp_src_row !== want.row ||
                rsp_in_frame !== want.in_frame) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t mismatch exp col=%0d row=%0d in=%0b got col=%0d row=%0d in=%0b",
                           $time, want.col, want.row, want.in_frame, rsp_src_col,
                           rsp_src_row, rsp_in_frame);
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [23:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         REG_FOCAL_X:  lens_fx = data[19:0];
         REG_FOCAL_Y:  lens_fy = data[19:0];
         REG_CENTER_X: lens_cx = data[19:0];
         REG_CENTER_Y: lens_cy = data[19:0];
         REG_K1:       lens_k1 = data;
         REG_K2:       lens_k2 = data;
         REG_P1:       lens_p1 = data;
         REG_P2:       lens_p2 = data;
         default: ;
      endcase
   endtask

   task automatic load_lens(input logic [23:0] fx, input logic [23:0] fy,
                            input logic [23:0] cx, input logic [23:0] cy,
                            input logic [23:0] k1, input logic [23:0] k2,
                            input logic [23:0] p1, input logic [23:0] p2);
      write_reg(REG_FOCAL_X, fx);
      write_reg(REG_FOCAL_Y, fy);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_K1, k1);
      write_reg(REG_K2, k2);
      write_reg(REG_P1, p1);
      write_reg(REG_P2, p2);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      cfg_sets++;
   endtask

   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_out_col <= col;
      req_out_row <= row;
      do @(posedge clock); while (busy);
      expected_coords.push_back(distort_pixel(col, row));
      pixels_sent++;
   endtask

   task automatic drain_pipeline();
      int guard;
      start <= 1'b0;
      guard = 0;
      while (expected_coords.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [11:0] rand_coord();
      if ($urandom_range(99) < 80) return 12'($urandom_range(2047));
      return 12'($urandom_range(4095));
   endfunction

   task automatic rand_lens();
      logic [23:0] fx, fy, cx, cy;
      if ($urandom_range(9) < 8) begin
         fx = 24'($urandom_range(300 * 256, 3000 * 256));
         fy = 24'($urandom_range(300 * 256, 3000 * 256));
         cx = 24'($urandom_range(800 * 256, 1250 * 256));
         cy = 24'($urandom_range(800 * 256, 1250 * 256));
         load_lens(fx | 24'($urandom_range(15) << 20), fy, cx,
                   cy | 24'($urandom_range(15) << 20),
                   24'($signed(24'($urandom_range(1 << 19))) - 24'sd262144),
                   24'($signed(24'($urandom_range(1 << 17))) - 24'sd65536),
                   24'($signed(24'($urandom_range(1 << 14))) - 24'sd8192),
                   24'($signed(24'($urandom_range(1 << 14))) - 24'sd8192));
      end else begin
         load_lens(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      end
   endtask

   task automatic test_identity_defaults();
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd1024, 12'd1024);
      send_pixel(12'd2047, 12'd2047);
      send_pixel(12'd2048, 12'd5);
      send_pixel(12'd4095, 12'd4095);
      drain_pipeline();
   endtask

   task automatic test_extreme_lens();
      // small focal (256), full-scale coefficients, corner pixels
      load_lens(24'd256, 24'd256, 24'd0, 24'hFFFFF,
                24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd2, 12'd4093);
      drain_pipeline();
      load_lens(24'hFFFFF, 24'hFFFFF, 24'hFFFFF, 24'd0,
                24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'hAAA, 12'h555);
      drain_pipeline();
      // mild barrel with tangential terms across the frame
      load_lens(24'd256000, 24'd250000, 24'd262144, 24'd262000,
                24'hFE6666, 24'h004000, 24'h000800, 24'hFFF800);
      send_pixel(12'd0, 12'd1024);
      send_pixel(12'd2047, 12'd1024);
      send_pixel(12'd1024, 12'd0);
      send_pixel(12'd1024, 12'd2047);
      send_pixel(12'd555, 12'd1700);
      drain_pipeline();
   endtask

   task automatic test_zero_focal();
      load_lens(24'd0, 24'd0, 24'd262144, 24'd262144, 24'd0, 24'd0, 24'd0, 24'd0);
      send_pixel(12'd1024, 12'd1024);
      send_pixel(12'd1025, 12'd1023);
      send_pixel(12'd0, 12'd4095);
      drain_pipeline();
   endtask

   task automatic test_random_phase(input int idle_pct, input int n_pixels);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < n_pixels; i++) begin
         if (i % 60 == 0) begin
            drain_pipeline();
            rand_lens();
         end
         send_pixel(rand_coord(), rand_coord());
      end
      drain_pipeline();
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_out_col      = '0;
      req_out_row      = '0;
      csr_write_enable = 1'b0;
      csr_index        = REG_FOCAL_X;
      csr_write_data   = '0;
      lens_fx = FOCAL_RESET;
      lens_fy = FOCAL_RESET;
      lens_cx = CENTER_RESET;
      lens_cy = CENTER_RESET;
      lens_k1 = '0;
      lens_k2 = '0;
      lens_p1 = '0;
      lens_p2 = '0;
      mismatches = 0;
      pixels_sent = 0;
      coords_checked = 0;
      in_frame_seen = 0;
      sender_idle_pct = 0;
      cfg_sets = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_defaults();
      test_extreme_lens();
      test_zero_focal();
      test_random_phase(25, 180);
      test_random_phase(74, 180);
      test_random_phase(0, 180);

      $display("covered %0d pixel requests over %0d lens settings, %0d responses checked",
               pixels_sent, cfg_sets, coords_checked);
      $display("%0d responses landed inside the source frame, %0d mismatches",
               in_frame_seen, mismatches);
      if (mismatches == 0 && expected_coords.size() == 0) begin
         $display("tb_lens_distortion_coordinate_map_core: PASS");
      end else begin
         $display("tb_lens_distortion_coordinate_map_core: FAIL");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("tb_lens_distortion_coordinate_map_core: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
